// ----- rtl/core/rrtt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtt_pkg
// Shared types and constants of the round-robin task table.
// ----------------------------------------------------------------------------
package rrtt_pkg;

  localparam int MaxTasks = 8;
  localparam int SlotW    = $clog2(MaxTasks);
  localparam int CountW   = $clog2(MaxTasks + 1);
  localparam int TagW     = 32;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_RUNNING = 2'd2
  } slot_e;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_START  = 3'd1,
    CMD_EXIT   = 3'd2,
    CMD_SELECT = 3'd3,
    CMD_SWITCH = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NO_TASK = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]      command;
    logic [TagW-1:0] task_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [2:0]      current_slot;
    logic            current_valid;
    logic [2:0]      next_slot;
    logic [3:0]      task_count;
    logic [TagW-1:0] current_tag;
  } rsp_t;

  // Per-cell command from the sequencer
  typedef struct packed {
    logic            shift;
    logic            wr_state;
    slot_e           state;
    logic            wr_tag;
    logic [TagW-1:0] tag;
  } cell_ctl_t;

  // Contents of one slot as seen by its neighbor and the sequencer
  typedef struct packed {
    slot_e           state;
    logic [TagW-1:0] tag;
  } cell_view_t;

endpackage

// ----- rtl/core/rrtt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtt_cell
// One task slot: state and tag, loaded from the upper neighbor on a shift or
// written directly by the sequencer.
// ----------------------------------------------------------------------------
module rrtt_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rrtt_pkg::cell_ctl_t    ctl_i,
  input  rrtt_pkg::cell_view_t   nbr_i,
  output rrtt_pkg::cell_view_t   view_o
);

  rrtt_pkg::slot_e                 state_q;
  logic [rrtt_pkg::TagW-1:0]       tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrtt_pkg::SLOT_EMPTY;
    end else if (ctl_i.shift) begin
      state_q <= nbr_i.state;
    end else if (ctl_i.wr_state) begin
      state_q <= ctl_i.state;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      tag_q <= nbr_i.tag;
    end else if (ctl_i.wr_tag) begin
      tag_q <= ctl_i.tag;
    end
  end

  assign view_o.state = state_q;
  assign view_o.tag   = tag_q;

endmodule

// ----- rtl/core/round_robin_task_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_task_table
// Task slot table with round-robin selection, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request (command, task_tag) enters on in_valid_i/in_ready_o; one
//   response per request leaves on out_valid_o/out_ready_i carrying status
//   and the scheduler view after the command.
//   Add, start, switch, spare codes, rejected commands and an exit that
//   empties the table go from the execute state straight to the response
//   state, which raises out_valid_o. Exit compacts the table by shifting
//   every cell above the current slot down to its neighbor, then runs a
//   selection. Select walks the cursor one slot per cycle until it finds a
//   live slot or has made a full lap. Flow: one request at a time; the
//   next request is taken as soon as the sequencer is back in idle, even
//   while the previous response still waits in the output register.
//   Reset empties all slots and clears count, cursor and current task.
//   A stalled receiver holds the response; the next finished response waits
//   in the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module round_robin_task_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rrtt_pkg::req_t    in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rrtt_pkg::rsp_t    out_rsp_o
);

  localparam int N  = rrtt_pkg::MaxTasks;
  localparam int SW = rrtt_pkg::SlotW;
  localparam int CW = rrtt_pkg::CountW;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_SINIT  = 5'b00100,
    ST_SEARCH = 5'b01000,
    ST_RESP   = 5'b10000
  } fsm_e;

  fsm_e                  state_q, state_d;
  rrtt_pkg::req_t        req_q;
  logic [CW-1:0]         count_q, count_d;
  logic [SW-1:0]         cursor_q, cursor_d;
  logic [SW-1:0]         first_q, first_d;
  logic [SW-1:0]         running_q, running_d;
  logic                  run_valid_q, run_valid_d;
  logic [SW-1:0]         chosen_q, chosen_d;
  rrtt_pkg::status_e     status_q, status_d;
  logic                  out_valid_q;
  rrtt_pkg::rsp_t        out_q;

  rrtt_pkg::cell_ctl_t   ctl  [N];
  rrtt_pkg::cell_view_t  view [N];
  logic [N-1:0]          occupied;

  logic                  exit_ok;
  logic                  run_in_range;
  logic                  out_load;
  logic [SW-1:0]         cursor_norm;
  logic [SW-1:0]         cursor_nxt;
  logic [CW-1:0]         count_dec;

  // Row of slot cells; the top cell shifts in an empty slot
  for (genvar g = 0; g < N; g++) begin : g_cell
    rrtt_pkg::cell_view_t nbr;
    if (g == N - 1) begin : g_top
      assign nbr.state = rrtt_pkg::SLOT_EMPTY;
      assign nbr.tag   = '0;
    end else begin : g_mid
      assign nbr = view[g+1];
    end
    rrtt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[g]),
      .nbr_i  (nbr),
      .view_o (view[g])
    );
    assign occupied[g] = (view[g].state == rrtt_pkg::SLOT_READY) ||
                         (view[g].state == rrtt_pkg::SLOT_RUNNING);
  end

  assign run_in_range = CW'(running_q) < count_q;
  assign exit_ok      = (count_q != '0) && run_valid_q && run_in_range;
  assign count_dec    = count_q - CW'(1);
  assign cursor_norm  = (CW'(cursor_q) >= count_q) ? '0 : cursor_q;
  assign cursor_nxt   = ((CW'(cursor_q) + CW'(1)) == count_q) ? '0 : cursor_q + SW'(1);

  // Per-cell commands for the execute cycle
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ctl[i].shift    = 1'b0;
      ctl[i].wr_state = 1'b0;
      ctl[i].state    = rrtt_pkg::SLOT_READY;
      ctl[i].wr_tag   = 1'b0;
      ctl[i].tag      = req_q.task_tag;
      if (state_q == ST_EXEC) begin
        case (rrtt_pkg::cmd_e'(req_q.command))
          rrtt_pkg::CMD_ADD: begin
            if (count_q < CW'(N) && CW'(i) == count_q) begin
              ctl[i].wr_state = 1'b1;
              ctl[i].wr_tag   = 1'b1;
            end
          end
          rrtt_pkg::CMD_START: begin
            if (count_q != '0 && i == 0) begin
              ctl[i].wr_state = 1'b1;
              ctl[i].state    = rrtt_pkg::SLOT_RUNNING;
            end
          end
          rrtt_pkg::CMD_EXIT: begin
            ctl[i].shift = exit_ok && (SW'(i) >= running_q);
          end
          rrtt_pkg::CMD_SWITCH: begin
            if (count_q != '0 && CW'(chosen_q) < count_q) begin
              if (SW'(i) == chosen_q) begin
                ctl[i].wr_state = 1'b1;
                ctl[i].state    = rrtt_pkg::SLOT_RUNNING;
              end else if (run_valid_q && run_in_range && SW'(i) == running_q) begin
                ctl[i].wr_state = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    first_d     = first_q;
    running_d   = running_q;
    run_valid_d = run_valid_q;
    chosen_d    = chosen_q;
    status_d    = status_q;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        status_d = rrtt_pkg::STAT_OK;
        state_d  = ST_RESP;
        case (rrtt_pkg::cmd_e'(req_q.command))
          rrtt_pkg::CMD_ADD: begin
            if (count_q >= CW'(N)) begin
              status_d = rrtt_pkg::STAT_FULL;
            end else begin
              count_d = count_q + CW'(1);
            end
          end
          rrtt_pkg::CMD_START: begin
            if (count_q == '0) begin
              status_d = rrtt_pkg::STAT_NO_TASK;
            end else begin
              running_d   = '0;
              run_valid_d = 1'b1;
              cursor_d    = '0;
            end
          end
          rrtt_pkg::CMD_EXIT: begin
            if (!exit_ok) begin
              status_d = rrtt_pkg::STAT_NO_TASK;
            end else begin
              count_d     = count_dec;
              run_valid_d = 1'b0;
              if (cursor_q != '0) begin
                cursor_d = cursor_q - SW'(1);
              end
              if (count_dec == '0) begin
                chosen_d = '0;
                status_d = rrtt_pkg::STAT_NO_TASK;
              end else begin
                state_d = ST_SINIT;
              end
            end
          end
          rrtt_pkg::CMD_SELECT: begin
            if (count_q == '0) begin
              status_d = rrtt_pkg::STAT_NO_TASK;
            end else begin
              state_d = ST_SINIT;
            end
          end
          rrtt_pkg::CMD_SWITCH: begin
            if (count_q == '0 || CW'(chosen_q) >= count_q) begin
              status_d = rrtt_pkg::STAT_NO_TASK;
            end else begin
              running_d   = chosen_q;
              run_valid_d = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SINIT: begin
        cursor_d = cursor_norm;
        first_d  = cursor_norm;
        state_d  = ST_SEARCH;
      end
      ST_SEARCH: begin
        // Examine one slot per cycle; stop on a live slot or a full lap
        chosen_d = cursor_q;
        cursor_d = cursor_nxt;
        if (cursor_nxt == first_q || occupied[cursor_q]) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      first_q     <= '0;
      running_q   <= '0;
      run_valid_q <= 1'b0;
      chosen_q    <= '0;
      status_q    <= rrtt_pkg::STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      first_q     <= first_d;
      running_q   <= running_d;
      run_valid_q <= run_valid_d;
      chosen_q    <= chosen_d;
      status_q    <= status_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      req_q <= in_req_i;
    end
    if (out_load) begin
      out_q.status        <= status_q;
      out_q.current_slot  <= 3'(running_q);
      out_q.current_valid <= run_valid_q;
      out_q.next_slot     <= 3'(chosen_q);
      out_q.task_count    <= 4'(count_q);
      out_q.current_tag   <= (run_valid_q && run_in_range) ? view[running_q].tag : '0;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
